>>> hw/rtl/hsfp_pkg.sv
// ----------------------------------------------------------------------------
// hsfp_pkg: shared types and constants of the floppy port model
// Request and result words, request kinds, register indexes and fixed codes.
// ----------------------------------------------------------------------------
package hsfp_pkg;

   localparam int DEF_SECTORS_PER_TRACK = 16;
   localparam int DEF_BYTES_PER_SECTOR  = 256;

   localparam int MEDIA_ADDR_W = 19;
   localparam int TRACK_W      = 8;
   localparam int ACT_W        = 3;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [7:0]         READ_CONTROL    = 8'h80;
   localparam logic [7:0]         READ_NO_MEDIA   = 8'hFF;
   localparam logic [7:0]         INDEX_FLAG      = 8'h80;
   localparam logic [ACT_W-1:0]   ACTIVITY_START  = 3'd6;
   localparam logic [TRACK_W-1:0] TRACK_MAX_40    = 8'd39;
   localparam logic [TRACK_W-1:0] TRACK_MAX_77    = 8'd76;
   localparam int                 CTRL_STEP_BIT   = 2;
   localparam int                 CTRL_INWARD_BIT = 3;

   typedef enum logic [2:0] {
      REQ_STATUS_READ   = 3'd0,
      REQ_INDEX_READ    = 3'd1,
      REQ_CONTROL_READ  = 3'd2,
      REQ_DATA_READ     = 3'd3,
      REQ_CONTROL_WRITE = 3'd4,
      REQ_TICK          = 3'd5
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DRIVE0_MOUNTED  = 2'd0,
      CSR_DRIVE1_MOUNTED  = 2'd1,
      CSR_DRIVE0_77_TRACK = 2'd2,
      CSR_DRIVE1_77_TRACK = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic               drive_select;
      logic               loader_mode;
      logic [3:0]         expected_sector;
      logic [3:0]         expected_id;
      logic [TRACK_W-1:0] requested_track;
      logic [TRACK_W-1:0] target_single;
      logic [TRACK_W-1:0] target_double;
      logic               double_sided;
      logic [7:0]         control_value;
      logic [7:0]         media_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0]              read_value;
      logic [MEDIA_ADDR_W-1:0] media_address;
      logic                    media_fetch;
      logic                    step_pulse;
      logic [ACT_W-1:0]        drive0_activity;
      logic [ACT_W-1:0]        drive1_activity;
   } rsp_word_type;

   // Handshake status of the input register as seen by the rest of the pipe
   typedef struct packed {
      logic valid;
      logic advance;
   } hsfp_stage_type;

endpackage

>>> hw/rtl/hsfp_req_if.sv
// ----------------------------------------------------------------------------
// hsfp_req_if: request channel
// Valid/ready channel carrying one bus access or tick per word.
// ----------------------------------------------------------------------------
interface hsfp_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic       drive_select;
   logic       loader_mode;
   logic [3:0] expected_sector;
   logic [3:0] expected_id;
   logic [7:0] requested_track;
   logic [7:0] target_single;
   logic [7:0] target_double;
   logic       double_sided;
   logic [7:0] control_value;
   logic [7:0] media_byte;

   modport source (
      output valid, req_type, drive_select, loader_mode, expected_sector, expected_id,
             requested_track, target_single, target_double, double_sided,
             control_value, media_byte,
      input  ready
   );

   modport sink (
      input  valid, req_type, drive_select, loader_mode, expected_sector, expected_id,
             requested_track, target_single, target_double, double_sided,
             control_value, media_byte,
      output ready
   );
endinterface

>>> hw/rtl/hsfp_rsp_if.sv
// ----------------------------------------------------------------------------
// hsfp_rsp_if: result channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface hsfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_value;
   logic [18:0] media_address;
   logic        media_fetch;
   logic        step_pulse;
   logic [2:0]  drive0_activity;
   logic [2:0]  drive1_activity;

   modport source (
      output valid, read_value, media_address, media_fetch, step_pulse,
             drive0_activity, drive1_activity,
      input  ready
   );

   modport sink (
      input  valid, read_value, media_address, media_fetch, step_pulse,
             drive0_activity, drive1_activity,
      output ready
   );
endinterface

>>> hw/rtl/hsfp_in_reg.sv
// ----------------------------------------------------------------------------
// hsfp_in_reg: request input register
// Captures one request word and releases it when the result register is free.
// ----------------------------------------------------------------------------
module hsfp_in_reg
   import hsfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_word_type   req_word,
   input  logic           out_free,
   output hsfp_stage_type stage,
   output req_word_type   held_word
);

   logic         valid_ff, valid_in;
   req_word_type word_ff;
   logic         advance;

   assign advance   = valid_ff & out_free;
   assign req_ready = ~valid_ff | out_free;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= req_word;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.advance = advance;
   assign held_word     = word_ff;

endmodule

>>> hw/rtl/hsfp_core.sv
// ----------------------------------------------------------------------------
// hsfp_core: drive state and request decode
// Holds the drive state and computes one result word per request.
// ----------------------------------------------------------------------------
module hsfp_core
   import hsfp_pkg::*;
#(
   parameter int SECTORS_PER_TRACK = DEF_SECTORS_PER_TRACK,
   parameter int BYTES_PER_SECTOR  = DEF_BYTES_PER_SECTOR
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_wdata,
   input  hsfp_stage_type         stage,
   input  req_word_type           req_word,
   output rsp_word_type           rsp_word
);

   localparam int SEC_W = ($clog2(SECTORS_PER_TRACK) > 4) ? $clog2(SECTORS_PER_TRACK) : 4;
   localparam int POS_W = $clog2(BYTES_PER_SECTOR + 3);
   localparam logic [POS_W-1:0] POS_SYNC       = '0;
   localparam logic [POS_W-1:0] POS_ID         = POS_W'(1);
   localparam logic [POS_W-1:0] POS_FIRST_DATA = POS_W'(2);
   localparam logic [POS_W-1:0] POS_LAST_DATA  = POS_W'(BYTES_PER_SECTOR + 1);
   localparam logic [POS_W-1:0] POS_CHECKSUM   = POS_W'(BYTES_PER_SECTOR + 2);

   // Sector after s, wrapped by the track length; s may be a loaded value
   // above the track length, so fold it down by repeated subtraction.
   function automatic logic [SEC_W-1:0] next_sector(input logic [SEC_W-1:0] s);
      logic [SEC_W:0] v;
      v = {1'b0, s} + (SEC_W+1)'(1);
      for (int i = 0; i < 8; i++) begin
         if (v >= (SEC_W+1)'(SECTORS_PER_TRACK)) begin
            v = v - (SEC_W+1)'(SECTORS_PER_TRACK);
         end
      end
      return v[SEC_W-1:0];
   endfunction

   logic [1:0]              mounted_ff;
   logic [1:0]              geom77_ff;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [SEC_W-1:0]        sector_ff, sector_in;
   logic [TRACK_W-1:0]      head_ff [2];
   logic [TRACK_W-1:0]      head_in [2];
   logic                    step_last_ff, step_last_in;
   logic [7:0]              sum_ff, sum_in;
   logic [MEDIA_ADDR_W-1:0] addr_ff, addr_in;
   logic                    fetch_ff, fetch_in;
   logic [ACT_W-1:0]        act_ff [2];
   logic [ACT_W-1:0]        act_in [2];

   logic                    drv;
   logic                    loader;
   logic                    sel_mounted;
   logic [TRACK_W-1:0]      sel_max;
   logic [TRACK_W-1:0]      sel_head;
   logic [3:0]              id_sector;
   logic [TRACK_W-1:0]      id_track;
   logic [TRACK_W-1:0]      id_track_clamped;
   logic [31:0]             id_addr_full;
   logic [7:0]              id_byte;
   logic [7:0]              data_byte;
   logic [TRACK_W-1:0]      target;
   logic [SEC_W-1:0]        sector_next;
   logic [7:0]              read_value;
   logic                    step_pulse;

   assign drv         = req_word.drive_select;
   assign loader      = req_word.loader_mode;
   assign sel_mounted = mounted_ff[drv];
   assign sel_max     = geom77_ff[drv] ? TRACK_MAX_77 : TRACK_MAX_40;
   assign sel_head    = head_ff[drv];
   assign sector_next = next_sector(sector_ff);

   // ID field: loader supplies sector and track, otherwise the current sector and the head position
   assign id_sector        = loader ? req_word.expected_sector : sector_ff[3:0];
   assign id_track         = loader ? req_word.requested_track : sel_head;
   assign id_track_clamped = (id_track > sel_max) ? sel_max : id_track;
   assign id_addr_full     = (32'(id_track_clamped) * 32'(SECTORS_PER_TRACK)
                              + 32'(id_sector)) * 32'(BYTES_PER_SECTOR);
   assign id_byte          = loader ? {4'b0, req_word.expected_id} : sel_head;
   assign data_byte        = fetch_ff ? req_word.media_byte : 8'h00;
   assign target           = req_word.double_sided ? req_word.target_double
                                                   : req_word.target_single;

   always_comb begin
      pos_in       = pos_ff;
      sector_in    = sector_ff;
      head_in      = head_ff;
      step_last_in = step_last_ff;
      sum_in       = sum_ff;
      addr_in      = addr_ff;
      fetch_in     = fetch_ff;
      act_in       = act_ff;
      read_value   = 8'h00;
      step_pulse   = 1'b0;

      case (req_kind_type'(req_word.req_type))
         REQ_STATUS_READ: begin
            read_value = {5'b0, sel_mounted, sel_mounted, (sel_head == '0)};
         end
         REQ_INDEX_READ: begin
            if (!sel_mounted) begin
               read_value = READ_NO_MEDIA;
            end else if (loader) begin
               sector_in  = SEC_W'(req_word.expected_sector);
               read_value = INDEX_FLAG | {4'b0, req_word.expected_sector};
            end else begin
               read_value = INDEX_FLAG | {4'b0, sector_ff[3:0]};
            end
         end
         REQ_CONTROL_READ: begin
            read_value = READ_CONTROL;
         end
         REQ_DATA_READ: begin
            if (pos_ff == POS_SYNC) begin
               pos_in   = POS_ID;
               fetch_in = 1'b0;
            end else if (pos_ff == POS_ID) begin
               if (loader) begin
                  sector_in    = SEC_W'(req_word.expected_sector);
                  head_in[drv] = req_word.requested_track;
               end
               sum_in   = 8'h00;
               fetch_in = 1'b0;
               addr_in  = '0;
               if (sel_mounted) begin
                  act_in[drv] = ACTIVITY_START;
                  addr_in     = id_addr_full[MEDIA_ADDR_W-1:0];
                  fetch_in    = 1'b1;
               end
               pos_in     = POS_FIRST_DATA;
               read_value = id_byte;
            end else if (pos_ff <= POS_LAST_DATA) begin
               if (fetch_ff) begin
                  sum_in  = sum_ff + data_byte;
                  addr_in = addr_ff + MEDIA_ADDR_W'(1);
               end
               pos_in = pos_ff + POS_W'(1);
               if (pos_ff == POS_LAST_DATA) begin
                  fetch_in = 1'b0;
                  addr_in  = '0;
               end
               read_value = data_byte;
            end else begin
               read_value = sum_ff;
               sector_in  = sector_next;
               pos_in     = POS_SYNC;
               fetch_in   = 1'b0;
               addr_in    = '0;
            end
         end
         REQ_CONTROL_WRITE: begin
            if (loader) begin
               if (req_word.control_value[CTRL_STEP_BIT] && !step_last_ff) begin
                  if (req_word.control_value[CTRL_INWARD_BIT]) begin
                     if (sel_head != '0) begin
                        head_in[drv] = sel_head - TRACK_W'(1);
                     end
                  end else if (sel_head < sel_max) begin
                     head_in[drv] = sel_head + TRACK_W'(1);
                  end
                  step_pulse = 1'b1;
               end
               step_last_in = req_word.control_value[CTRL_STEP_BIT];
            end else begin
               if (sel_head < target && sel_head < sel_max) begin
                  head_in[drv] = sel_head + TRACK_W'(1);
               end else if (sel_head > target) begin
                  head_in[drv] = sel_head - TRACK_W'(1);
               end
               step_pulse = 1'b1;
            end
         end
         REQ_TICK: begin
            sector_in = sector_next;
            pos_in    = POS_SYNC;
            fetch_in  = 1'b0;
            addr_in   = '0;
            for (int i = 0; i < 2; i++) begin
               if (act_ff[i] != '0) begin
                  act_in[i] = act_ff[i] - ACT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mounted_ff <= '0;
         geom77_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DRIVE0_MOUNTED:  mounted_ff[0] <= csr_wdata;
            CSR_DRIVE1_MOUNTED:  mounted_ff[1] <= csr_wdata;
            CSR_DRIVE0_77_TRACK: geom77_ff[0]  <= csr_wdata;
            CSR_DRIVE1_77_TRACK: geom77_ff[1]  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_SYNC;
         sector_ff    <= '0;
         head_ff[0]   <= '0;
         head_ff[1]   <= '0;
         step_last_ff <= 1'b0;
         sum_ff       <= '0;
         addr_ff      <= '0;
         fetch_ff     <= 1'b0;
         act_ff[0]    <= '0;
         act_ff[1]    <= '0;
      end else if (stage.advance) begin
         pos_ff       <= pos_in;
         sector_ff    <= sector_in;
         head_ff      <= head_in;
         step_last_ff <= step_last_in;
         sum_ff       <= sum_in;
         addr_ff      <= addr_in;
         fetch_ff     <= fetch_in;
         act_ff       <= act_in;
      end
   end

   assign rsp_word.read_value      = read_value;
   assign rsp_word.media_address   = fetch_in ? addr_in : '0;
   assign rsp_word.media_fetch     = fetch_in;
   assign rsp_word.step_pulse      = step_pulse;
   assign rsp_word.drive0_activity = act_in[0];
   assign rsp_word.drive1_activity = act_in[1];

   // Fetching is only live inside the media part of a sector
   a_fetch_window: assert property (@(posedge clock) disable iff (reset)
      fetch_ff |-> (pos_ff >= POS_FIRST_DATA && pos_ff <= POS_LAST_DATA))
      else $error("fetch enabled outside media bytes");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_CHECKSUM)
      else $error("stream position past checksum");

   a_activity_bound: assert property (@(posedge clock) disable iff (reset)
      act_ff[0] <= ACTIVITY_START && act_ff[1] <= ACTIVITY_START)
      else $error("activity count above start value");

   a_tick_restart: assert property (@(posedge clock) disable iff (reset)
      (stage.advance && req_word.req_type == REQ_TICK) |=> (pos_ff == POS_SYNC && !fetch_ff))
      else $error("tick did not restart the stream");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !stage.valid |=> ($stable(pos_ff) && $stable(sector_ff) && $stable(sum_ff)))
      else $error("stream state moved without a request");

endmodule

>>> hw/rtl/hsfp_out_reg.sv
// ----------------------------------------------------------------------------
// hsfp_out_reg: result register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module hsfp_out_reg
   import hsfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  hsfp_stage_type stage,
   input  rsp_word_type   rsp_word,
   output logic           out_free,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_word_type   rsp_held
);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   assign out_free = ~valid_ff | rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (stage.advance) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage.advance) begin
         word_ff <= rsp_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_held  = word_ff;

endmodule

>>> hw/rtl/hard_sector_floppy_port_model.sv
// ----------------------------------------------------------------------------
// hard_sector_floppy_port_model: two-drive hard-sectored floppy port
// Bus accesses and ticks in, one result word out per request.
// ----------------------------------------------------------------------------
// Each request word is one bus access (status, index, control or data read,
// control write) or one sector tick, and produces exactly one result word.
// A word is captured in an input register, decoded against the drive state in
// a single pass of short logic and captured in the result register, which
// offers the result to the consumer; one word is taken every cycle as long as
// the consumer keeps up. The input register keeps taking a word while a
// finished result waits to be taken, and only both registers full with rsp
// ready low hold the input back. Data reads walk a sector stream of sync
// byte, ID byte, BYTES_PER_SECTOR media bytes and checksum.
// When media_fetch is high in a result, the next data read must carry in
// media_byte the image byte at media_address. Write the csr_ registers only
// while no request is in flight.
module hard_sector_floppy_port_model
   import hsfp_pkg::*;
#(
   parameter int SECTORS_PER_TRACK = DEF_SECTORS_PER_TRACK,
   parameter int BYTES_PER_SECTOR  = DEF_BYTES_PER_SECTOR
)(
   input  logic                   clock,
   input  logic                   reset,
   hsfp_req_if.sink               req_chan,
   hsfp_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_wdata
);

   req_word_type   req_word;
   req_word_type   held_word;
   rsp_word_type   rsp_word;
   rsp_word_type   rsp_held;
   hsfp_stage_type stage;
   logic           out_free;

   // Gather the request fields into one word
   assign req_word.req_type        = req_chan.req_type;
   assign req_word.drive_select    = req_chan.drive_select;
   assign req_word.loader_mode     = req_chan.loader_mode;
   assign req_word.expected_sector = req_chan.expected_sector;
   assign req_word.expected_id     = req_chan.expected_id;
   assign req_word.requested_track = req_chan.requested_track;
   assign req_word.target_single   = req_chan.target_single;
   assign req_word.target_double   = req_chan.target_double;
   assign req_word.double_sided    = req_chan.double_sided;
   assign req_word.control_value   = req_chan.control_value;
   assign req_word.media_byte      = req_chan.media_byte;

   // Input register: advance when the result register can take the word
   hsfp_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_word  (req_word),
      .out_free  (out_free),
      .stage     (stage),
      .held_word (held_word)
   );

   // Drive state, configuration and decode
   hsfp_core #(
      .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
      .BYTES_PER_SECTOR  (BYTES_PER_SECTOR)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stage     (stage),
      .req_word  (held_word),
      .rsp_word  (rsp_word)
   );

   // Result register: hold the word until the consumer takes it
   hsfp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .rsp_word  (rsp_word),
      .out_free  (out_free),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_held  (rsp_held)
   );

   // Spread the result word onto the channel
   assign rsp_chan.read_value      = rsp_held.read_value;
   assign rsp_chan.media_address   = rsp_held.media_address;
   assign rsp_chan.media_fetch     = rsp_held.media_fetch;
   assign rsp_chan.step_pulse      = rsp_held.step_pulse;
   assign rsp_chan.drive0_activity = rsp_held.drive0_activity;
   assign rsp_chan.drive1_activity = rsp_held.drive1_activity;

endmodule

>>> sim/tb_hard_sector_floppy_port_model.sv
// ----------------------------------------------------------------------------
// tb_hard_sector_floppy_port_model: self-checking bench for the floppy port
// Drives bus accesses and ticks through the request channel, mirrors the
// drive state in a scoreboard and checks every result word field by field,
// under several drive setups and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_hard_sector_floppy_port_model;
   import hsfp_pkg::*;

   localparam int SECTORS        = DEF_SECTORS_PER_TRACK;
   localparam int SECTOR_BYTES   = DEF_BYTES_PER_SECTOR;
   localparam int STREAM_LEN     = SECTOR_BYTES + 3;   // sync, ID, media, sum
   localparam int REQ_W          = $bits(req_word_type);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_WORDS    = 130;

   localparam logic [2:0] REQ_SPARE_LO   = 3'd6;
   localparam logic [2:0] REQ_SPARE_HI   = 3'd7;
   localparam logic [7:0] STATUS_TRACK0  = 8'h01;
   localparam logic [7:0] STATUS_MOUNTED = 8'h06;

   // -------------------------------------------------------------------------
   // Scoreboard: a mirror of the drive state plus the queue of result words
   // still owed by the block.
   // -------------------------------------------------------------------------
   class floppy_port_mirror;
      bit                    mounted[2];
      bit                    has_77[2];
      bit [8:0]              stream_pos;
      bit [3:0]              cur_sector;
      bit [TRACK_W-1:0]      head[2];
      bit                    step_last;
      bit [7:0]              byte_sum;
      bit [MEDIA_ADDR_W-1:0] fetch_addr;
      bit                    fetch_on;
      bit [ACT_W-1:0]        activity[2];
      rsp_word_type          owed_results[$];
      int                    errors;

      function new();
         errors = 0;
      endfunction

      function void set_register(csr_index_type idx, bit v);
         case (idx)
            CSR_DRIVE0_MOUNTED:  mounted[0] = v;
            CSR_DRIVE1_MOUNTED:  mounted[1] = v;
            CSR_DRIVE0_77_TRACK: has_77[0] = v;
            CSR_DRIVE1_77_TRACK: has_77[1] = v;
            default: ;
         endcase
      endfunction

      function bit [TRACK_W-1:0] top_track(bit d);
         return has_77[d] ? TRACK_MAX_77 : TRACK_MAX_40;
      endfunction

      function bit [3:0] after_sector(bit [3:0] s);
         return 4'((int'(s) + 1) % SECTORS);
      endfunction

      // One data read: walk the sector stream by one byte.
      function bit [7:0] stream_byte(req_word_type w);
         bit               d;
         bit [3:0]         sec;
         bit [TRACK_W-1:0] trk;
         bit [7:0]         id;
         bit [7:0]         v;
         d = w.drive_select;
         if (stream_pos == 0) begin
            stream_pos = 1;
            fetch_on = 0;
            return 8'h00;
         end
         if (stream_pos == 1) begin
            if (w.loader_mode) begin
               id = {4'h0, w.expected_id};
               sec = w.expected_sector;
               trk = w.requested_track;
               cur_sector = sec;
               head[d] = trk;
            end else begin
               sec = cur_sector;
               id = head[d];
               trk = head[d];
            end
            byte_sum = 0;
            fetch_on = 0;
            fetch_addr = 0;
            if (mounted[d]) begin
               if (trk > top_track(d)) trk = top_track(d);
               activity[d] = ACTIVITY_START;
               fetch_addr = MEDIA_ADDR_W'((int'(trk) * SECTORS + int'(sec)) * SECTOR_BYTES);
               fetch_on = 1;
            end
            stream_pos = 2;
            return id;
         end
         if (stream_pos <= SECTOR_BYTES + 1) begin
            v = 8'h00;
            if (fetch_on) begin
               v = w.media_byte;
               byte_sum = byte_sum + v;
               fetch_addr = fetch_addr + 1'b1;
            end
            stream_pos = stream_pos + 1'b1;
            if (stream_pos > SECTOR_BYTES + 1) begin
               fetch_on = 0;
               fetch_addr = 0;
            end
            return v;
         end
         v = byte_sum;
         cur_sector = after_sector(cur_sector);
         stream_pos = 0;
         fetch_on = 0;
         fetch_addr = 0;
         return v;
      endfunction

      // Note one accepted request word and queue the result it must produce.
      function void take_access(req_word_type w);
         rsp_word_type     r;
         bit               d;
         bit [7:0]         rv;
         bit               pulse;
         bit [3:0]         s;
         bit [TRACK_W-1:0] tgt;
         d = w.drive_select;
         rv = 8'h00;
         pulse = 0;
         case (w.req_type)
            REQ_STATUS_READ: begin
               if (head[d] == 0) rv |= STATUS_TRACK0;
               if (mounted[d]) rv |= STATUS_MOUNTED;
            end
            REQ_INDEX_READ: begin
               if (!mounted[d]) begin
                  rv = READ_NO_MEDIA;
               end else begin
                  s = cur_sector;
                  if (w.loader_mode) begin
                     s = w.expected_sector;
                     cur_sector = s;
                  end
                  rv = INDEX_FLAG | {4'h0, s};
               end
            end
            REQ_CONTROL_READ: rv = READ_CONTROL;
            REQ_DATA_READ: rv = stream_byte(w);
            REQ_CONTROL_WRITE: begin
               if (w.loader_mode) begin
                  if (w.control_value[CTRL_STEP_BIT] && !step_last) begin
                     if (w.control_value[CTRL_INWARD_BIT]) begin
                        if (head[d] > 0) head[d] = head[d] - 1'b1;
                     end else if (head[d] < top_track(d)) begin
                        head[d] = head[d] + 1'b1;
                     end
                     pulse = 1;
                  end
                  step_last = w.control_value[CTRL_STEP_BIT];
               end else begin
                  tgt = w.double_sided ? w.target_double : w.target_single;
                  if (head[d] < tgt && head[d] < top_track(d)) head[d] = head[d] + 1'b1;
                  else if (head[d] > tgt) head[d] = head[d] - 1'b1;
                  pulse = 1;
               end
            end
            REQ_TICK: begin
               cur_sector = after_sector(cur_sector);
               stream_pos = 0;
               fetch_on = 0;
               fetch_addr = 0;
               if (activity[0] != 0) activity[0] = activity[0] - 1'b1;
               if (activity[1] != 0) activity[1] = activity[1] - 1'b1;
            end
            default: ;
         endcase
         r.read_value      = rv;
         r.media_address   = fetch_on ? fetch_addr : '0;
         r.media_fetch     = fetch_on;
         r.step_pulse      = pulse;
         r.drive0_activity = activity[0];
         r.drive1_activity = activity[1];
         owed_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (owed_results.size() == 0) begin
            $error("result word with no access waiting: read_value %0h", got.read_value);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         compare_field("read_value", 32'(want.read_value), 32'(got.read_value));
         compare_field("media_address", 32'(want.media_address), 32'(got.media_address));
         compare_field("media_fetch", 32'(want.media_fetch), 32'(got.media_fetch));
         compare_field("step_pulse", 32'(want.step_pulse), 32'(got.step_pulse));
         compare_field("drive0_activity", 32'(want.drive0_activity),
                       32'(got.drive0_activity));
         compare_field("drive1_activity", 32'(want.drive1_activity),
                       32'(got.drive1_activity));
      endfunction

      function int pending();
         return owed_results.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, channels and the block
   // -------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   csr_wdata;

   hsfp_req_if req_chan();
   hsfp_rsp_if rsp_chan();

   floppy_port_mirror mirror = new();

   int           sender_idle_pct;
   int           receiver_stall_pct;
   int           accesses_sent;
   int           quiet_cycles;
   req_word_type seen_req;
   rsp_word_type seen_rsp;
   bit           moved;

   always #1 clock = ~clock;

   hard_sector_floppy_port_model #(
      .SECTORS_PER_TRACK(SECTORS),
      .BYTES_PER_SECTOR (SECTOR_BYTES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge, before the block's
   // registers move. Feed accepted requests to the mirror first; a result
   // never leaves in the same cycle its request enters, so the order is safe.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (!reset) begin
         moved = 0;
         if (req_chan.valid && req_chan.ready) begin
            seen_req.req_type        = req_chan.req_type;
            seen_req.drive_select    = req_chan.drive_select;
            seen_req.loader_mode     = req_chan.loader_mode;
            seen_req.expected_sector = req_chan.expected_sector;
            seen_req.expected_id     = req_chan.expected_id;
            seen_req.requested_track = req_chan.requested_track;
            seen_req.target_single   = req_chan.target_single;
            seen_req.target_double   = req_chan.target_double;
            seen_req.double_sided    = req_chan.double_sided;
            seen_req.control_value   = req_chan.control_value;
            seen_req.media_byte      = req_chan.media_byte;
            mirror.take_access(seen_req);
            moved = 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_rsp.read_value      = rsp_chan.read_value;
            seen_rsp.media_address   = rsp_chan.media_address;
            seen_rsp.media_fetch     = rsp_chan.media_fetch;
            seen_rsp.step_pulse      = rsp_chan.step_pulse;
            seen_rsp.drive0_activity = rsp_chan.drive0_activity;
            seen_rsp.drive1_activity = rsp_chan.drive1_activity;
            mirror.check_result(seen_rsp);
            moved = 1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // Watchdog: drop the run once neither channel has moved for too long.
   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("tb_hard_sector_floppy_port_model: done, errors");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Build a request word of the given kind, drive and mode; every other field is random.
   function automatic req_word_type pick(logic [2:0] kind, bit drive, bit loader);
      req_word_type w;
      w = REQ_W'({$urandom, $urandom});
      w.req_type = kind;
      w.drive_select = drive;
      w.loader_mode = loader;
      return w;
   endfunction

   function automatic logic [2:0] any_kind();
      int r;
      r = $urandom_range(99);
      if (r < 30) return REQ_DATA_READ;
      if (r < 52) return REQ_CONTROL_WRITE;
      if (r < 64) return REQ_TICK;
      if (r < 73) return REQ_STATUS_READ;
      if (r < 83) return REQ_INDEX_READ;
      if (r < 92) return REQ_CONTROL_READ;
      return ($urandom_range(1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
   endfunction

   function automatic logic [2:0] side_read_kind();
      case ($urandom_range(2))
         0:       return REQ_STATUS_READ;
         1:       return REQ_INDEX_READ;
         default: return REQ_CONTROL_READ;
      endcase
   endfunction

   // Offer one word and hold it until the block takes it. Idle cycles go in
   // front of the word, so valid never drops and rises in one step.
   task automatic send_access(input req_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.req_type        <= w.req_type;
      req_chan.drive_select    <= w.drive_select;
      req_chan.loader_mode     <= w.loader_mode;
      req_chan.expected_sector <= w.expected_sector;
      req_chan.expected_id     <= w.expected_id;
      req_chan.requested_track <= w.requested_track;
      req_chan.target_single   <= w.target_single;
      req_chan.target_double   <= w.target_double;
      req_chan.double_sided    <= w.double_sided;
      req_chan.control_value   <= w.control_value;
      req_chan.media_byte      <= w.media_byte;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      accesses_sent++;
   endtask

   // Drop valid and hold until every owed result word has come back.
   task automatic hold_until_settled();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (mirror.pending() != 0) @(posedge clock);
   endtask

   // Write all four drive registers, one per cycle; the block is idle here.
   task automatic write_registers(input bit m0, input bit m1, input bit t0, input bit t1);
      bit            vals[4];
      csr_index_type idx;
      vals = '{m0, m1, t0, t1};
      for (int i = 0; i < 4; i++) begin
         idx = csr_index_type'(i);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[i];
         mirror.set_register(idx, vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Hand-picked opening: every access kind, the field extremes and the
   // corner cases of the stream and the stepper.
   task automatic run_directed();
      req_word_type w;
      // drive 0 mounted with 40 tracks, drive 1 empty with 77 tracks
      write_registers(1'b1, 1'b0, 1'b0, 1'b1);
      w = pick(REQ_STATUS_READ, 0, 0);   send_access(w);   // track 0, mounted
      w = pick(REQ_STATUS_READ, 1, 1);   send_access(w);   // track 0, empty
      w = pick(REQ_INDEX_READ, 1, 1);    send_access(w);   // empty drive index
      w = pick(REQ_INDEX_READ, 0, 1);
      w.expected_sector = 4'hF;          send_access(w);   // loader sector
      w = pick(REQ_CONTROL_READ, 0, 0);  send_access(w);
      w = pick(REQ_DATA_READ, 0, 0);     send_access(w);   // sync byte
      // loader ID with a track far past the end: head stored raw, address clamped
      w = pick(REQ_DATA_READ, 0, 1);
      w.expected_id = 4'hF;
      w.expected_sector = 4'hF;
      w.requested_track = 8'hFF;         send_access(w);
      w = pick(REQ_DATA_READ, 0, 0);
      w.media_byte = 8'hFF;              send_access(w);
      w = pick(REQ_DATA_READ, 0, 1);
      w.media_byte = 8'h00;              send_access(w);
      w = pick(REQ_TICK, 0, 0);          send_access(w);   // cut the stream
      // loader stepping: inward edge at track 0 pulses but cannot move
      w = pick(REQ_CONTROL_WRITE, 1, 1);
      w.control_value = 8'h0C;           send_access(w);
      w = pick(REQ_CONTROL_WRITE, 1, 1);
      w.control_value = 8'hFF;           send_access(w);   // no new edge
      w = pick(REQ_CONTROL_WRITE, 1, 1);
      w.control_value = 8'h00;           send_access(w);
      w = pick(REQ_CONTROL_WRITE, 1, 1);
      w.control_value = 8'h04;           send_access(w);   // step outward
      // after boot: head already on target, then seek toward track 0
      w = pick(REQ_CONTROL_WRITE, 0, 0);
      w.double_sided = 1'b1;
      w.target_double = 8'hFF;
      w.target_single = 8'h00;           send_access(w);
      w = pick(REQ_CONTROL_WRITE, 0, 0);
      w.double_sided = 1'b0;
      w.target_single = 8'h00;           send_access(w);
      // empty drive streams zero media bytes
      w = pick(REQ_DATA_READ, 1, 0);     send_access(w);
      w = pick(REQ_DATA_READ, 1, 0);     send_access(w);
      w = pick(REQ_DATA_READ, 1, 0);
      w.media_byte = 8'hFF;              send_access(w);
      w = pick(REQ_STATUS_READ, 1, 0);   send_access(w);   // off track 0
      w = pick(REQ_SPARE_LO, 0, 0);      send_access(w);
      w = pick(REQ_SPARE_HI, 1, 1);      send_access(w);
      w = pick(REQ_INDEX_READ, 0, 0);    send_access(w);
      w = pick(REQ_DATA_READ, 0, 0);     send_access(w);
   endtask

   // Read one whole sector after a tick; now and then cut it short or slip
   // a side read in between.
   task automatic read_sector();
      req_word_type w;
      bit           d;
      bit           loader;
      int           cut;
      d = 1'($urandom_range(1));
      loader = 1'($urandom_range(1));
      cut = ($urandom_range(9) == 0) ? $urandom_range(STREAM_LEN - 1) : STREAM_LEN;
      w = pick(REQ_TICK, d, loader);
      send_access(w);
      for (int i = 0; i < STREAM_LEN; i++) begin
         if (i == cut) begin
            w = pick(REQ_TICK, d, loader);
            send_access(w);
            return;
         end
         if ($urandom_range(19) == 0) begin
            w = pick(side_read_kind(), d, loader);
            send_access(w);
         end
         w = pick(REQ_DATA_READ, d, loader);
         send_access(w);
      end
   endtask

   // A run of control writes toward one end or a random target, now and then
   // with a status read in between.
   task automatic seek_run();
      req_word_type     w;
      bit               d;
      bit               loader;
      bit               inward;
      bit [TRACK_W-1:0] tgt;
      int               n;
      d = 1'($urandom_range(1));
      loader = 1'($urandom_range(1));
      inward = 1'($urandom_range(1));
      n = $urandom_range(90, 20);
      case ($urandom_range(2))
         0:       tgt = '0;
         1:       tgt = '1;
         default: tgt = TRACK_W'($urandom);
      endcase
      for (int i = 0; i < n; i++) begin
         w = pick(REQ_CONTROL_WRITE, d, loader);
         if (loader) begin
            w.control_value[CTRL_STEP_BIT] = i[0];
            w.control_value[CTRL_INWARD_BIT] = inward;
         end else begin
            w.target_single = tgt;
            w.target_double = tgt;
         end
         send_access(w);
         if ($urandom_range(9) == 0) begin
            w = pick(REQ_STATUS_READ, d, loader);
            send_access(w);
         end
      end
   endtask

   task automatic mixed_burst();
      req_word_type w;
      int           n;
      n = $urandom_range(25, 5);
      repeat (n) begin
         w = pick(any_kind(), 1'($urandom_range(1)), 1'($urandom_range(1)));
         send_access(w);
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int start;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.req_type = '0;
      req_chan.drive_select = 1'b0;
      req_chan.loader_mode = 1'b0;
      req_chan.expected_sector = '0;
      req_chan.expected_id = '0;
      req_chan.requested_track = '0;
      req_chan.target_single = '0;
      req_chan.target_double = '0;
      req_chan.double_sided = 1'b0;
      req_chan.control_value = '0;
      req_chan.media_byte = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      accesses_sent = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      hold_until_settled();

      // Each phase: settle, set the drives, pick an idle pattern, then mostly
      // well-formed sector reads and seeks with random bursts in between.
      for (int phase = 0; phase < 5; phase++) begin
         hold_until_settled();
         case (phase)
            0:       write_registers(1'b0, 1'b0, 1'b0, 1'b0);
            1:       write_registers(1'b1, 1'b1, 1'b1, 1'b1);
            default: write_registers(1'($urandom_range(1)), 1'($urandom_range(1)),
                                     1'($urandom_range(1)), 1'($urandom_range(1)));
         endcase
         case (phase % 4)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
            default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
         endcase
         start = accesses_sent;
         while (accesses_sent - start < PHASE_WORDS) begin
            case ($urandom_range(99) / 5)
               0, 1, 2, 3, 4, 5, 6: read_sector();
               7, 8, 9:             seek_run();
               default:             mixed_burst();
            endcase
         end
      end

      // Drain the pipe, let the last word clear, then report.
      hold_until_settled();
      repeat (4) @(posedge clock);
      if (mirror.errors == 0 && mirror.pending() == 0) begin
         $display("tb_hard_sector_floppy_port_model: done, clean");
      end else begin
         $display("tb_hard_sector_floppy_port_model: done, errors");
      end
      $finish;
   end

endmodule
